// File: sv/isrt_pkg.sv
package isrt_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic  ins;
    logic  pop;
    data_t din;
  } ctrl_t;

endpackage

// File: sv/isrt_cell.sv
module isrt_cell (
  input  logic            clk,
  input  isrt_pkg::ctrl_t ctrl,
  input  logic            occ,
  input  logic            prev_keep,
  input  isrt_pkg::data_t prev_val,
  input  isrt_pkg::data_t next_val,
  output logic            keep,
  output isrt_pkg::data_t val
);

  isrt_pkg::data_t val_r;
  isrt_pkg::data_t val_nxt;

  always_comb begin
    keep    = occ && (val_r < ctrl.din);
    val_nxt = val_r;
    if (ctrl.ins && !keep) begin
      val_nxt = prev_keep ? ctrl.din : prev_val;
    end else if (ctrl.pop) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// File: sv/insertion_sorter.sv
// Insertion sorter over a row of CAPACITY compare/shift cells. While a set is
// being loaded one value is taken every cycle: all cells compare against the
// new value at once, and the value lands ahead of the first stored value that
// is greater than or equal to it while the cells above shift up by one. The
// request carrying tlast is stored too; then the input stalls while the row
// shifts down one cell per cycle into the output register, one result per
// cycle unless the sink stalls. Values arriving while the row is full are
// dropped and every result of that set carries tuser = 1. The final result of
// a set has tlast = 1. A new set may start loading while the last result
// still waits.
module insertion_sorter #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value
  output logic        out_tlast,
  output logic        out_tuser   // [0] dropped
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  isrt_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  isrt_pkg::data_t  out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_user_r, out_user_nxt;

  isrt_pkg::ctrl_t  ctrl;
  logic             in_acc;
  logic             pop;
  logic             full;

  isrt_pkg::data_t  vals [CAPACITY];
  logic             keeps [CAPACITY];

  assign in_tready = (state_r == isrt_pkg::ST_FILL);
  assign in_acc    = in_tvalid && in_tready;
  assign full      = (fill_r >= CAP_C);
  assign pop       = (state_r == isrt_pkg::ST_DRAIN) && (!out_valid_r || out_tready);

  assign ctrl.ins = in_acc && !full;
  assign ctrl.pop = pop;
  assign ctrl.din = isrt_pkg::data_t'(in_tdata);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    isrt_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (IDX < fill_r),
      .prev_keep ((i == 0) ? 1'b1 : keeps[(i == 0) ? 0 : i - 1]),
      .prev_val  (vals[(i == 0) ? 0 : i - 1]),
      .next_val  (vals[(i == CAPACITY - 1) ? i : i + 1]),
      .keep      (keeps[i]),
      .val       (vals[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      isrt_pkg::ST_FILL: begin
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            fill_nxt = fill_r + ONE_C;
          end
          if (in_tlast) begin
            state_nxt = isrt_pkg::ST_DRAIN;
          end
        end
      end
      isrt_pkg::ST_DRAIN: begin
        if (pop) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = vals[0];
          out_last_nxt  = (fill_r == ONE_C);
          out_user_nxt  = ovf_r;
          fill_nxt      = fill_r - ONE_C;
          if (fill_r == ONE_C) begin
            state_nxt = isrt_pkg::ST_FILL;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: state_nxt = isrt_pkg::ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= isrt_pkg::ST_FILL;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CAP_C)
    else $error("fill count above capacity");

  a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r >= CW'(2)) |-> (vals[0] <= vals[1]))
    else $error("first two cells out of order");

  a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && fill_r == ONE_C) |=> (fill_r == '0 && state_r == isrt_pkg::ST_FILL
                                  && out_tvalid && out_tlast))
    else $error("drain did not end cleanly");

  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && full) |=> (ovf_r || (out_tvalid && out_tuser)))
    else $error("dropped request not flagged");

endmodule
